@@ hw/rtl/lewg_pkg.sv @@
// Shared types, codes and constants of the LED effect waveform generator.
// Used by lewg_div, lewg_ctrl, lewg_dp and led_effect_waveform_generator.
// No dependencies.
package lewg_pkg;

    // Fixed-point layout
    localparam int PHASE_BITS   = 16;
    localparam int SINE_ENTRIES = 256;
    localparam int IDX_BITS     = $clog2(SINE_ENTRIES);
    localparam int TICK_MS      = 20;
    localparam int ELAPSED_MAX  = 2047;

    // Shared divider: quotient always fits QUO_W bits, so the first
    // DVD_W - QUO_W dividend bits load straight into the remainder.
    localparam int DVD_W     = 35;
    localparam int DVS_W     = 19;
    localparam int QUO_W     = 17;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // sin(pi*u) approximation 16p/(5N^2 - 4p), scaled to Q16
    localparam int RCOS_DEN_BASE = 5 * SINE_ENTRIES * SINE_ENTRIES;
    localparam int RCOS_SHIFT    = 20;

    // Effect modes
    localparam logic [2:0] MODE_CONST   = 3'd0;
    localparam logic [2:0] MODE_ALT     = 3'd1;
    localparam logic [2:0] MODE_BREATHE = 3'd2;
    localparam logic [2:0] MODE_DRIFT   = 3'd3;
    localparam logic [2:0] MODE_SPARKLE = 3'd4;

    // Drive codes
    localparam logic [1:0] DRV_OFF  = 2'd0;
    localparam logic [1:0] DRV_POS  = 2'd1;
    localparam logic [1:0] DRV_NEG  = 2'd2;
    localparam logic [1:0] DRV_BOTH = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_SPEED  = 2'd1;
    localparam logic [1:0] CFG_BRIGHT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [2:0] MODE_RESET   = MODE_CONST;
    localparam logic [6:0] SPEED_RESET  = 7'd30;
    localparam logic [7:0] BRIGHT_RESET = 8'd255;

    localparam logic [6:0] SPEED_MIN = 7'd1;
    localparam logic [6:0] SPEED_MAX = 7'd100;

    // Chaos and flicker constants
    localparam logic [6:0] CHAOS_GOAL_BASE = 7'd50;
    localparam int         CHAOS_STEP      = 5;
    localparam int         CHAOS_DIV       = 100;
    localparam int         FLICK_BASE      = 550;
    localparam int         FLICK_GAIN      = 3;
    localparam int         FLICK_FULL      = 1000;

    // Divide by 100 and by 1000 as floor(x * M >> k), exact for x below
    // 2^15 and 2^18 respectively
    localparam int CHAOS_RECIP       = 20972;
    localparam int CHAOS_RECIP_SHIFT = 21;
    localparam int FLICK_RECIP       = 67109;
    localparam int FLICK_RECIP_SHIFT = 26;

    typedef struct packed {
        logic [5:0] chaos_draw;
        logic [6:0] flicker_draw;
    } tick_t;

    typedef struct packed {
        logic [7:0] duty_a;
        logic [7:0] duty_b;
        logic [1:0] drive;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PINC,
        S_PSTEP,
        S_RCOS,
        S_SCALE,
        S_CHAOS,
        S_LSTART,
        S_LDIV,
        S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        DIV_PHASE,
        DIV_RCOS
    } div_sel_t;

    typedef enum logic [1:0] {
        DUTY_ZERO,
        DUTY_BRIGHT,
        DUTY_LEVEL,
        DUTY_SCALE
    } duty_src_t;

    typedef struct packed {
        logic      load_in;
        logic      div_start;
        div_sel_t  div_sel;
        logic      phase_add;
        logic      chaos_upd;
        logic      lvl_load;
        logic      sq_load;
        logic      duty_load;
        duty_src_t duty_src;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic       div_done;
        logic       bright_zero;
        logic [2:0] mode;
    } status_t;

endpackage

@@ hw/rtl/lewg_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the phase-step and raised-cosine divisions.
// Depends on lewg_pkg for widths and step count.
module lewg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lewg_pkg::DVD_W-1:0]  dividend,
    input  logic [lewg_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [lewg_pkg::QUO_W-1:0]  quotient
);

    logic [lewg_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [lewg_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [lewg_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [lewg_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       done_reg, done_next;
    logic [lewg_pkg::DVS_W:0]   trial;
    logic [lewg_pkg::DVS_W:0]   diff;
    logic                       ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[lewg_pkg::QUO_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});

        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        count_next = count_reg;
        done_next  = 1'b0;

        if (start)
        begin
            // Upper dividend bits are known to be below the divisor
            rem_next   = {1'b0, dividend[lewg_pkg::DVD_W-1:lewg_pkg::QUO_W]};
            quo_next   = dividend[lewg_pkg::QUO_W-1:0];
            dvs_next   = divisor;
            count_next = lewg_pkg::CNT_W'(lewg_pkg::DIV_STEPS);
        end
        else if (count_reg != '0)
        begin
            rem_next   = ge ? diff[lewg_pkg::DVS_W-1:0] : trial[lewg_pkg::DVS_W-1:0];
            quo_next   = {quo_reg[lewg_pkg::QUO_W-2:0], ge};
            count_next = count_reg - lewg_pkg::CNT_W'(1);
            done_next  = (count_reg == lewg_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/lewg_ctrl.sv @@
// Sequencer of the waveform generator: accepts ticks, steps the datapath,
// and owns the result valid flag. Depends on lewg_pkg.
module lewg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick_valid,
    output logic              tick_stall,
    output logic              result_valid,
    input  logic              result_stall,
    input  lewg_pkg::status_t status,
    output lewg_pkg::cmd_t    cmd
);

    lewg_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             out_free;

    assign accept   = tick_valid && (state_reg == lewg_pkg::S_IDLE);
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lewg_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (status.bright_zero || status.mode == lewg_pkg::MODE_CONST)
                        state_next = lewg_pkg::S_RESULT;
                    else
                        state_next = lewg_pkg::S_PINC;
                end
            end
            lewg_pkg::S_PINC:
            begin
                if (status.div_done)
                    state_next = lewg_pkg::S_PSTEP;
            end
            lewg_pkg::S_PSTEP:
            begin
                case (status.mode)
                    lewg_pkg::MODE_ALT,
                    lewg_pkg::MODE_BREATHE: state_next = lewg_pkg::S_RCOS;
                    lewg_pkg::MODE_DRIFT:   state_next = lewg_pkg::S_CHAOS;
                    lewg_pkg::MODE_SPARKLE: state_next = lewg_pkg::S_LSTART;
                    default:                state_next = lewg_pkg::S_RESULT;
                endcase
            end
            lewg_pkg::S_RCOS:
            begin
                if (status.div_done)
                    state_next = lewg_pkg::S_SCALE;
            end
            lewg_pkg::S_SCALE:  state_next = lewg_pkg::S_RESULT;
            lewg_pkg::S_CHAOS:  state_next = lewg_pkg::S_LSTART;
            lewg_pkg::S_LSTART: state_next = lewg_pkg::S_LDIV;
            lewg_pkg::S_LDIV:   state_next = lewg_pkg::S_RESULT;
            lewg_pkg::S_RESULT:
            begin
                if (out_free)
                    state_next = lewg_pkg::S_IDLE;
            end
            default: state_next = lewg_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.div_sel   = lewg_pkg::DIV_PHASE;
        cmd.duty_src  = lewg_pkg::DUTY_ZERO;
        case (state_reg)
            lewg_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    if (status.bright_zero)
                    begin
                        cmd.duty_load = 1'b1;
                        cmd.duty_src  = lewg_pkg::DUTY_ZERO;
                    end
                    else if (status.mode == lewg_pkg::MODE_CONST)
                    begin
                        cmd.duty_load = 1'b1;
                        cmd.duty_src  = lewg_pkg::DUTY_BRIGHT;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = lewg_pkg::DIV_PHASE;
                    end
                end
            end
            lewg_pkg::S_PINC:
            begin
                cmd.phase_add = status.div_done;
            end
            lewg_pkg::S_PSTEP:
            begin
                case (status.mode)
                    lewg_pkg::MODE_ALT,
                    lewg_pkg::MODE_BREATHE:
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = lewg_pkg::DIV_RCOS;
                    end
                    lewg_pkg::MODE_DRIFT,
                    lewg_pkg::MODE_SPARKLE: ;
                    default:
                    begin
                        // unused mode codes: phase moved, output off
                        cmd.duty_load = 1'b1;
                        cmd.duty_src  = lewg_pkg::DUTY_ZERO;
                    end
                endcase
            end
            lewg_pkg::S_RCOS:
            begin
                cmd.sq_load = status.div_done;
            end
            lewg_pkg::S_SCALE:
            begin
                cmd.duty_load = 1'b1;
                cmd.duty_src  = lewg_pkg::DUTY_SCALE;
            end
            lewg_pkg::S_CHAOS:
            begin
                cmd.chaos_upd = 1'b1;
            end
            lewg_pkg::S_LSTART:
            begin
                cmd.lvl_load = 1'b1;
            end
            lewg_pkg::S_LDIV:
            begin
                cmd.duty_load = 1'b1;
                cmd.duty_src  = lewg_pkg::DUTY_LEVEL;
            end
            lewg_pkg::S_RESULT:
            begin
                cmd.out_load = out_free;
            end
            default: ;
        endcase
    end

    // Hold the result while the receiver stalls
    assign out_valid_next = cmd.out_load || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lewg_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign tick_stall   = (state_reg != lewg_pkg::S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

@@ hw/rtl/lewg_dp.sv @@
// Datapath of the waveform generator: configuration, phase and chaos state,
// raised-cosine and scaling arithmetic, result register.
// Depends on lewg_pkg and lewg_div.
module lewg_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  lewg_pkg::tick_t   tick,
    input  lewg_pkg::cmd_t    cmd,
    output lewg_pkg::status_t status,
    output lewg_pkg::result_t result
);

    // Configuration
    logic [2:0] mode_reg,   mode_next;
    logic [6:0] speed_reg,  speed_next;
    logic [7:0] bright_reg, bright_next;

    // Effect state
    logic [lewg_pkg::PHASE_BITS-1:0] phase_reg, phase_next;
    logic signed [7:0]               level_reg, level_next;
    logic [6:0]                      goal_reg,  goal_next;
    logic [10:0]                     elapsed_reg, elapsed_next;

    // Working registers
    lewg_pkg::tick_t    draw_reg;
    logic [16:0]        sq_reg;
    logic [17:0]        lvl_x_reg;
    logic [7:0]         duty_reg;
    logic [1:0]         drive_reg;
    lewg_pkg::result_t  result_reg;

    logic [6:0]                      sp;
    logic [lewg_pkg::IDX_BITS-1:0]   idx;
    logic [17:0]                     p_full;
    logic [14:0]                     p;
    logic [lewg_pkg::DVS_W-1:0]      rcos_den;
    logic [14:0]                     lvl_prod;
    logic [9:0]                      flick_raw;
    logic [9:0]                      flick;
    logic [17:0]                     flick_prod;
    logic [17:0]                     lvl_x;
    logic [16:0]                     lvl_recip;
    logic [34:0]                     lvl_mul;
    logic [13:0]                     lvl_quo;
    logic [lewg_pkg::DVD_W-1:0]      dvd;
    logic [lewg_pkg::DVS_W-1:0]      dvs;
    logic                            div_done;
    logic [lewg_pkg::QUO_W-1:0]      quo;
    logic [33:0]                     sq_full;
    logic [24:0]                     scale_full;
    logic [7:0]                      duty_sel;
    logic [1:0]                      drive_sel;
    logic [11:0]                     elapsed_sum;
    logic [9:0]                      chaos_limit;
    logic                            new_goal;
    logic [6:0]                      goal_use;
    logic signed [8:0]               level_step;
    logic [lewg_pkg::PHASE_BITS-1:0] phase_inc;

    // Speed used clamped to its legal range
    always_comb
    begin
        if (speed_reg < lewg_pkg::SPEED_MIN)
            sp = lewg_pkg::SPEED_MIN;
        else if (speed_reg > lewg_pkg::SPEED_MAX)
            sp = lewg_pkg::SPEED_MAX;
        else
            sp = speed_reg;
    end

    // Raised-cosine operands from the phase
    always_comb
    begin
        if (mode_reg == lewg_pkg::MODE_ALT)
            idx = phase_reg[lewg_pkg::PHASE_BITS-2 -: lewg_pkg::IDX_BITS];
        else
            idx = phase_reg[lewg_pkg::PHASE_BITS-1 -: lewg_pkg::IDX_BITS];
        p_full   = 18'({1'b0, idx} * (9'(lewg_pkg::SINE_ENTRIES) - {1'b0, idx}));
        p        = p_full[14:0];
        rcos_den = lewg_pkg::DVS_W'(lewg_pkg::RCOS_DEN_BASE)
                 - {2'b00, p, 2'b00};
    end

    // Level products, registered, then a reciprocal multiply for the
    // divide by 100 or 1000
    always_comb
    begin
        if (level_reg > 8'sd0)
            lvl_prod = 15'(level_reg[6:0] * bright_reg);
        else
            lvl_prod = '0;
        flick_raw = 10'(lewg_pkg::FLICK_BASE)
                  + 10'({3'b000, draw_reg.flicker_draw} * 10'(lewg_pkg::FLICK_GAIN));
        flick      = (flick_raw > 10'(lewg_pkg::FLICK_FULL)) ?
                     10'(lewg_pkg::FLICK_FULL) : flick_raw;
        flick_prod = 18'(flick * bright_reg);

        if (mode_reg == lewg_pkg::MODE_DRIFT)
        begin
            lvl_x     = {3'b000, lvl_prod};
            lvl_recip = 17'(lewg_pkg::CHAOS_RECIP);
        end
        else
        begin
            lvl_x     = flick_prod;
            lvl_recip = 17'(lewg_pkg::FLICK_RECIP);
        end
        lvl_mul = 35'(lvl_x_reg * lvl_recip);
        if (mode_reg == lewg_pkg::MODE_DRIFT)
            lvl_quo = lvl_mul[34:lewg_pkg::CHAOS_RECIP_SHIFT];
        else
            lvl_quo = {5'b00000, lvl_mul[34:lewg_pkg::FLICK_RECIP_SHIFT]};
    end

    // Divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            lewg_pkg::DIV_PHASE:
            begin
                dvd = lewg_pkg::DVD_W'(1) << lewg_pkg::PHASE_BITS;
                dvs = lewg_pkg::DVS_W'(sp * 9'd5);
            end
            lewg_pkg::DIV_RCOS:
            begin
                dvd = lewg_pkg::DVD_W'(p) << lewg_pkg::RCOS_SHIFT;
                dvs = rcos_den;
            end
            default:
            begin
                dvd = '0;
                dvs = lewg_pkg::DVS_W'(1);
            end
        endcase
    end

    lewg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    assign sq_full    = 34'(quo * quo);
    assign scale_full = 25'(sq_reg * bright_reg);
    assign phase_inc  = quo[lewg_pkg::PHASE_BITS-1:0];

    // Duty and drive for the current item
    always_comb
    begin
        case (cmd.duty_src)
            lewg_pkg::DUTY_ZERO:   duty_sel = '0;
            lewg_pkg::DUTY_BRIGHT: duty_sel = bright_reg;
            lewg_pkg::DUTY_LEVEL:  duty_sel = (lvl_quo > 14'd255) ? 8'd255 : lvl_quo[7:0];
            lewg_pkg::DUTY_SCALE:
                duty_sel = scale_full[24] ? 8'd255 : scale_full[23:16];
            default:               duty_sel = '0;
        endcase

        if (bright_reg == '0)
            drive_sel = lewg_pkg::DRV_OFF;
        else
        begin
            case (mode_reg)
                lewg_pkg::MODE_CONST,
                lewg_pkg::MODE_BREATHE,
                lewg_pkg::MODE_DRIFT,
                lewg_pkg::MODE_SPARKLE: drive_sel = lewg_pkg::DRV_BOTH;
                lewg_pkg::MODE_ALT:
                    drive_sel = phase_reg[lewg_pkg::PHASE_BITS-1] ?
                                lewg_pkg::DRV_NEG : lewg_pkg::DRV_POS;
                default:                drive_sel = lewg_pkg::DRV_OFF;
            endcase
        end
    end

    // Chaos slew: take a new goal when the hold time has run out
    always_comb
    begin
        elapsed_sum = {1'b0, elapsed_reg} + 12'(lewg_pkg::TICK_MS);
        chaos_limit = 10'(sp * 10'd10);
        new_goal    = (elapsed_reg > {1'b0, chaos_limit});
        goal_use    = new_goal ?
                      (lewg_pkg::CHAOS_GOAL_BASE + {1'b0, draw_reg.chaos_draw}) : goal_reg;
        if ($signed({level_reg[7], level_reg}) < $signed({2'b00, goal_use}))
            level_step = {level_reg[7], level_reg} + 9'sd5;
        else
            level_step = {level_reg[7], level_reg} - 9'sd5;
    end

    // Next state of configuration and effect registers
    always_comb
    begin
        mode_next    = mode_reg;
        speed_next   = speed_reg;
        bright_next  = bright_reg;
        phase_next   = phase_reg;
        level_next   = level_reg;
        goal_next    = goal_reg;
        elapsed_next = elapsed_reg;

        if (cmd.phase_add)
            phase_next = phase_reg + phase_inc;

        if (cmd.load_in)
            elapsed_next = (elapsed_sum > 12'(lewg_pkg::ELAPSED_MAX)) ?
                           11'(lewg_pkg::ELAPSED_MAX) : elapsed_sum[10:0];

        if (cmd.chaos_upd)
        begin
            if (new_goal)
            begin
                elapsed_next = '0;
                goal_next    = goal_use;
            end
            if (level_step > 9'sd127)
                level_next = 8'sd127;
            else if (level_step < -9'sd128)
                level_next = -8'sd128;
            else
                level_next = level_step[7:0];
        end

        if (cfg_we)
        begin
            case (cfg_index)
                lewg_pkg::CFG_MODE:
                begin
                    // A real mode change restarts the phase
                    if (cfg_data[2:0] != mode_reg)
                    begin
                        mode_next  = cfg_data[2:0];
                        phase_next = '0;
                    end
                end
                lewg_pkg::CFG_SPEED:  speed_next  = cfg_data[6:0];
                lewg_pkg::CFG_BRIGHT: bright_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= lewg_pkg::MODE_RESET;
            speed_reg   <= lewg_pkg::SPEED_RESET;
            bright_reg  <= lewg_pkg::BRIGHT_RESET;
            phase_reg   <= '0;
            level_reg   <= '0;
            goal_reg    <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            speed_reg   <= speed_next;
            bright_reg  <= bright_next;
            phase_reg   <= phase_next;
            level_reg   <= level_next;
            goal_reg    <= goal_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            draw_reg <= tick;
        if (cmd.sq_load)
            sq_reg <= sq_full[32:16];
        if (cmd.lvl_load)
            lvl_x_reg <= lvl_x;
        if (cmd.duty_load)
        begin
            duty_reg  <= duty_sel;
            drive_reg <= drive_sel;
        end
        if (cmd.out_load)
        begin
            result_reg.drive <= drive_reg;
            case (drive_reg)
                lewg_pkg::DRV_POS:
                begin
                    result_reg.duty_a <= duty_reg;
                    result_reg.duty_b <= '0;
                end
                lewg_pkg::DRV_NEG:
                begin
                    result_reg.duty_a <= '0;
                    result_reg.duty_b <= duty_reg;
                end
                lewg_pkg::DRV_BOTH:
                begin
                    result_reg.duty_a <= {1'b0, duty_reg[7:1]};
                    result_reg.duty_b <= {1'b0, duty_reg[7:1]};
                end
                default:
                begin
                    result_reg.duty_a <= '0;
                    result_reg.duty_b <= '0;
                end
            endcase
        end
    end

    assign status.div_done    = div_done;
    assign status.bright_zero = (bright_reg == '0);
    assign status.mode        = mode_reg;
    assign result             = result_reg;

endmodule

@@ hw/rtl/led_effect_waveform_generator.sv @@
// LED effect waveform generator for two anti-parallel LED channels.
//
// Channels: one tick request in (tick_valid/tick_stall, payload tick with two
// random draws), one result request out (result_valid/result_stall, payload
// result with duty_a, duty_b and drive). A request moves at a clock edge with
// valid high and stall low. Registers are written through cfg_we/cfg_index/
// cfg_data: 0 effect mode, 1 speed, 2 brightness; write only while idle.
//
// From tick accept to result valid: brightness zero or constant mode goes
// straight to the result state; else the phase step runs, then unused modes
// load zero, alternating and breathing a scaled raised cosine, and chaos
// (after a slew) and flicker a registered reciprocal multiply. The phase step
// and raised cosine each take one pass of the shared one-bit-per-cycle
// divider (17 steps); one tick is in flight at a time, tick_stall high while
// it is worked on, so a new tick is taken only once the block is idle again.
// The result sits in an output register, so the next tick is taken while a
// finished result still waits under result_stall; the block then waits to
// load its next result until the old one is taken.
// Reset: mode constant, speed 30, brightness 255, phase and chaos state zero,
// no result pending.
module led_effect_waveform_generator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick_valid,
    output logic              tick_stall,
    input  lewg_pkg::tick_t   tick,
    output logic              result_valid,
    input  logic              result_stall,
    output lewg_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data
);

    lewg_pkg::cmd_t    cmd;
    lewg_pkg::status_t status;

    lewg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    lewg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule
